// File: design/sle_pkg.sv
// Shared constants, codes and types of the sequential list engine.
`default_nettype none
package sle_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int LEN_W      = $clog2(CAPACITY + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [LEN_W-1:0]      len_t;

    typedef enum logic [3:0] {
        OP_CREATE  = 4'd0,
        OP_DESTROY = 4'd1,
        OP_CLEAR   = 4'd2,
        OP_GET     = 4'd3,
        OP_LOCATE  = 4'd4,
        OP_PRED    = 4'd5,
        OP_SUCC    = 4'd6,
        OP_INSERT  = 4'd7,
        OP_DELETE  = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_NOLIST   = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_GATHER
    } state_t;

    // how the picked one-hot moves before it selects a cell
    typedef enum logic [1:0] {
        SH_NONE,
        SH_DOWN,
        SH_UP
    } shift_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        word_t value;
        len_t  len;
        len_t  pos_m1;
        logic  wr_ins;
        logic  wr_del;
    } cell_cmd_t;

endpackage
`default_nettype wire

// File: design/sequential_list_engine.sv
// Top level of the sequential list engine: control, cell chain and result port.
//
// Usage
// -----
// One ordered list of up to CAPACITY (64) signed 32-bit words. An item is an
// operation code with a 1-based position and a value; it is taken at a rising
// edge where start is high and busy is low. Every item gives exactly one
// result: status, result_value, found_position, current_length and is_empty,
// shown for one cycle with done high. The receiver cannot stall; a result must
// be taken in the cycle it is shown.
//
// Steps: an item passes through S_PICK and S_GATHER. In S_PICK every cell
// compares its word against the value (or the position is decoded) and the
// first hit is registered; in S_GATHER the hit cell's word is gathered, the
// status formed, the chain shifts for insert/delete and the result register
// loads. done is high in the next cycle, where busy is already low, so a new
// item can be taken while the result is shown. Insert and delete move all
// later words at once since each cell loads from its neighbor.
//
// Reset (rst_n low, asynchronous) leaves no list and length 0. Cell contents
// are not cleared; a cell is only read once an insert has written it.
`default_nettype none
module sequential_list_engine
    import sle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  operation,
    input  wire logic [6:0]  position,
    input  wire logic [31:0] value,
    output logic             done,
    output logic [2:0]       status,
    output logic [31:0]      result_value,
    output logic [6:0]       found_position,
    output logic [6:0]       current_length,
    output logic             is_empty
);

    // -------------------------------------------------------------------
    // Control and list state
    // -------------------------------------------------------------------
    state_t      state_reg, state_next;
    logic        exists_reg, exists_next;
    len_t        len_reg, len_next;

    // latched item
    logic [3:0]  op_reg;
    logic [6:0]  pos_reg;
    word_t       val_reg;

    // result registers
    logic        done_reg;
    logic [2:0]  status_reg, status_next;
    word_t       rval_reg, rval_next;
    logic [6:0]  fpos_reg, fpos_next;

    logic        accept;
    logic        wr_ins, wr_del;
    len_t        pos_m1;
    logic [LEN_W:0] pos_w, len_w;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign pos_w  = (LEN_W+1)'(pos_reg);
    assign len_w  = (LEN_W+1)'(len_reg);
    assign pos_m1 = LEN_W'(pos_reg - 7'd1);

    // -------------------------------------------------------------------
    // Cell chain
    // -------------------------------------------------------------------
    cell_cmd_t           cmd;
    word_t               cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_in;

    assign cmd.value  = val_reg;
    assign cmd.len    = len_reg;
    assign cmd.pos_m1 = pos_m1;
    assign cmd.wr_ins = wr_ins;
    assign cmd.wr_del = wr_del;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        word_t left_d, right_d;
        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        sle_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(g)),
            .left_data  (left_d),
            .right_data (right_d),
            .cmd        (cmd),
            .data       (cell_data[g]),
            .eq         (cell_eq[g]),
            .in_range   (cell_in[g])
        );
    end

    // -------------------------------------------------------------------
    // Hit vector per operation, first-hit picker
    // -------------------------------------------------------------------
    logic [CAPACITY-1:0] hits;
    logic [CAPACITY-1:0] addr_hit;
    logic [CAPACITY-1:0] onehot;
    logic                found;
    shift_t              shift;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            addr_hit[i] = (LEN_W'(i) == pos_m1);
    end

    always_comb
    begin
        hits  = '0;
        shift = SH_NONE;
        unique case (op_reg)
            OP_LOCATE: hits = cell_eq & cell_in;
            OP_PRED:
            begin
                // match must not be at the head
                hits  = cell_eq & cell_in & ~CAPACITY'(1);
                shift = SH_DOWN;
            end
            OP_SUCC:
            begin
                // match must have a following element
                hits  = cell_eq & (cell_in >> 1);
                shift = SH_UP;
            end
            OP_GET, OP_DELETE: hits = addr_hit;
            default: hits = '0;
        endcase
    end

    sle_first u_first (
        .clk    (clk),
        .load   (state_reg == S_PICK),
        .hits   (hits),
        .shift  (shift),
        .onehot (onehot),
        .found  (found)
    );

    // gather the selected word and encode the hit index
    word_t        gathered;
    logic [IDX_W-1:0] hit_idx;

    always_comb
    begin
        gathered = '0;
        hit_idx  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            gathered = gathered | (cell_data[i] & {DATA_WIDTH{onehot[i]}});
            hit_idx  = hit_idx | (IDX_W'(i) & {IDX_W{onehot[i]}});
        end
    end

    // -------------------------------------------------------------------
    // FSM: next state, status, list update
    // -------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        exists_next = exists_reg;
        len_next    = len_reg;
        status_next = ST_OK;
        rval_next   = '0;
        fpos_next   = '0;
        wr_ins      = 1'b0;
        wr_del      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                state_next = S_GATHER;
            end
            S_GATHER:
            begin
                state_next = S_IDLE;
                if (op_reg == OP_CREATE)
                begin
                    if (exists_reg)
                        status_next = ST_BADPOS;
                    else
                    begin
                        exists_next = 1'b1;
                        len_next    = '0;
                    end
                end
                else if (!exists_reg)
                    status_next = ST_NOLIST;
                else
                begin
                    unique case (op_reg)
                        OP_DESTROY:
                        begin
                            exists_next = 1'b0;
                            len_next    = '0;
                        end
                        OP_CLEAR: len_next = '0;
                        OP_GET:
                        begin
                            if (pos_w == '0 || pos_w > len_w)
                                status_next = ST_BADPOS;
                            else
                                rval_next = gathered;
                        end
                        OP_LOCATE:
                        begin
                            if (found)
                                fpos_next = 7'(hit_idx) + 7'd1;
                            else
                                status_next = ST_NOTFOUND;
                        end
                        OP_PRED, OP_SUCC:
                        begin
                            if (found)
                                rval_next = gathered;
                            else
                                status_next = ST_NOTFOUND;
                        end
                        OP_INSERT:
                        begin
                            if (pos_w == '0 || pos_w > len_w + (LEN_W+1)'(1))
                                status_next = ST_BADPOS;
                            else if (len_w >= (LEN_W+1)'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                wr_ins   = 1'b1;
                                len_next = len_reg + len_t'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_w == '0 || pos_w > len_w)
                                status_next = ST_BADPOS;
                            else
                            begin
                                rval_next = gathered;
                                wr_del    = 1'b1;
                                len_next  = len_reg - len_t'(1);
                            end
                        end
                        default: status_next = ST_OK;   // unused codes
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            exists_reg <= 1'b0;
            len_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            exists_reg <= exists_next;
            len_reg    <= len_next;
            done_reg   <= (state_reg == S_GATHER);
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            val_reg <= value;
        end
        if (state_reg == S_GATHER)
        begin
            status_reg <= status_next;
            rval_reg   <= rval_next;
            fpos_reg   <= fpos_next;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign result_value   = rval_reg;
    assign found_position = fpos_reg;
    assign current_length = 7'(len_reg);
    assign is_empty       = exists_reg && (len_reg == '0);

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= len_t'(CAPACITY))
        else $error("list length above capacity");

    a_nolist_len: assert property (@(posedge clk) disable iff (!rst_n)
        !exists_reg |-> len_reg == '0)
        else $error("length nonzero without a list");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 !done ##1 done)
        else $error("item did not give exactly one result on time");

    a_shift_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ins || wr_del) |-> (state_reg == S_GATHER && !(wr_ins && wr_del)))
        else $error("chain shift outside the update cycle");

endmodule
`default_nettype wire

// File: design/sle_cell.sv
// One storage cell of the list chain: holds one word, compares, shifts.
`default_nettype none
module sle_cell
    import sle_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] idx,
    input  wire word_t            left_data,
    input  wire word_t            right_data,
    input  wire cell_cmd_t        cmd,
    output word_t                 data,
    output logic                  eq,
    output logic                  in_range
);

    word_t data_reg;
    word_t data_next;
    len_t  idx_ext;

    assign idx_ext  = LEN_W'(idx);
    assign data     = data_reg;
    assign eq       = (data_reg == cmd.value);
    assign in_range = (idx_ext < cmd.len);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.wr_ins)
        begin
            if (idx_ext == cmd.pos_m1)
                data_next = cmd.value;
            else if (idx_ext > cmd.pos_m1)
                data_next = left_data;   // move up
        end
        else if (cmd.wr_del)
        begin
            if (idx_ext >= cmd.pos_m1)
                data_next = right_data;  // move down
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// File: design/sle_first.sv
// First-hit picker: lowest set bit of the hit vector, registered, optionally moved.
`default_nettype none
module sle_first
    import sle_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                load,
    input  wire logic [CAPACITY-1:0] hits,
    input  wire shift_t              shift,
    output logic [CAPACITY-1:0]      onehot,
    output logic                     found
);

    logic [CAPACITY-1:0] lowest;
    logic [CAPACITY-1:0] onehot_reg;
    logic [CAPACITY-1:0] onehot_next;
    logic                found_reg;

    assign lowest = hits & (~hits + CAPACITY'(1));

    always_comb
    begin
        unique case (shift)
            SH_DOWN: onehot_next = lowest >> 1;
            SH_UP:   onehot_next = lowest << 1;
            default: onehot_next = lowest;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            onehot_reg <= onehot_next;
            found_reg  <= |hits;
        end
    end

    assign onehot = onehot_reg;
    assign found  = found_reg;

endmodule
`default_nettype wire

// File: tb/sequential_list_engine_tb.sv
// Self-checking testbench for the sequential list engine, with a scoreboard.
`default_nettype none
module sequential_list_engine_tb
    import sle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Number of random items after the directed opening.
    localparam int RANDOM_ITEMS = 700;
    // Highest operation code the 4-bit field can carry; codes above OP_DELETE
    // are unused and must leave the list alone.
    localparam logic [3:0] OP_CODE_MAX   = 4'hF;
    localparam logic [3:0] OP_UNUSED_LOW = OP_DELETE + 4'd1;

    // One result as seen on the output ports.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] rvalue;
        logic [6:0]  fpos;
        logic [6:0]  length;
        logic        empty;
    } outcome_t;

    // Stimulus flavors for the random part.
    typedef enum int {
        PH_MIX,
        PH_GROW,
        PH_SHRINK,
        PH_NOISE,
        PH_LIFECYCLE,
        PH_FILL
    } phase_t;

    // Mirror of the list: updated at each accepted item, queues the outcome
    // that item must produce and checks outcomes as they come out.
    class list_tracker;
        word_t    cells [CAPACITY];
        int       len;
        bit       list_live;
        outcome_t pending_outcomes [$];
        int       failures;
        int       checked;
        int       peak_len;
        int       full_refusals;

        function void note_request(logic [3:0] op, logic [6:0] pos, logic [31:0] val);
            outcome_t o;
            int       p;
            int       i;
            bit       hit;
            o   = '0;
            p   = int'(pos);
            hit = 1'b0;
            o.status = ST_OK;
            if (op == OP_CREATE)
            begin
                // a second create is refused with the bad-position code
                if (list_live)
                    o.status = ST_BADPOS;
                else
                begin
                    list_live = 1'b1;
                    len       = 0;
                end
            end
            else if (!list_live)
                o.status = ST_NOLIST;
            else
            begin
                case (op)
                    OP_DESTROY:
                    begin
                        list_live = 1'b0;
                        len       = 0;
                    end
                    OP_CLEAR: len = 0;
                    OP_GET:
                    begin
                        if (p < 1 || p > len)
                            o.status = ST_BADPOS;
                        else
                            o.rvalue = cells[p-1];
                    end
                    OP_LOCATE:
                    begin
                        o.status = ST_NOTFOUND;
                        for (i = 0; i < len && !hit; i++)
                            if (cells[i] == val)
                            begin
                                hit      = 1'b1;
                                o.status = ST_OK;
                                o.fpos   = 7'(i + 1);
                            end
                    end
                    OP_PRED:
                    begin
                        // first match from position 2 on; its left neighbor
                        o.status = ST_NOTFOUND;
                        for (i = 1; i < len && !hit; i++)
                            if (cells[i] == val)
                            begin
                                hit      = 1'b1;
                                o.status = ST_OK;
                                o.rvalue = cells[i-1];
                            end
                    end
                    OP_SUCC:
                    begin
                        // first match short of the last entry; its right neighbor
                        o.status = ST_NOTFOUND;
                        for (i = 0; i + 1 < len && !hit; i++)
                            if (cells[i] == val)
                            begin
                                hit      = 1'b1;
                                o.status = ST_OK;
                                o.rvalue = cells[i+1];
                            end
                    end
                    OP_INSERT:
                    begin
                        if (p < 1 || p > len + 1)
                            o.status = ST_BADPOS;
                        else if (len >= CAPACITY)
                            o.status = ST_FULL;
                        else
                        begin
                            for (i = len; i >= p; i--)
                                cells[i] = cells[i-1];
                            cells[p-1] = val;
                            len++;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (p < 1 || p > len)
                            o.status = ST_BADPOS;
                        else
                        begin
                            o.rvalue = cells[p-1];
                            for (i = p - 1; i + 1 < len; i++)
                                cells[i] = cells[i+1];
                            len--;
                        end
                    end
                    default: ;
                endcase
            end
            o.length = 7'(len);
            o.empty  = list_live && (len == 0);
            if (len > peak_len)
                peak_len = len;
            pending_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t ns MISMATCH %s: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_response(outcome_t got);
            outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                failures++;
                $display("%0t ns MISMATCH unexpected result: expected none, actual 0x%0h",
                         $time, got);
                return;
            end
            want = pending_outcomes.pop_front();
            checked++;
            if (got.status == ST_FULL)
                full_refusals++;
            compare_field("status",         32'(want.status), 32'(got.status));
            compare_field("result_value",   want.rvalue,      got.rvalue);
            compare_field("found_position", 32'(want.fpos),   32'(got.fpos));
            compare_field("current_length", 32'(want.length), 32'(got.length));
            compare_field("is_empty",       32'(want.empty),  32'(got.empty));
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        start          = 1'b0;
    logic [3:0]  operation      = OP_CREATE;
    logic [6:0]  position       = '0;
    logic [31:0] value          = '0;
    logic        busy;
    logic        done;
    logic [2:0]  status;
    logic [31:0] result_value;
    logic [6:0]  found_position;
    logic [6:0]  current_length;
    logic        is_empty;

    list_tracker tracker;
    logic [31:0] value_pool [8];
    int          ops_seen [16];
    int          items_sent;
    int          burst_left;
    int          drains;
    outcome_t    seen;

    sequential_list_engine i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .done           (done),
        .status         (status),
        .result_value   (result_value),
        .found_position (found_position),
        .current_length (current_length),
        .is_empty       (is_empty)
    );

    always #5 clk = ~clk;

    // Result side: done is a one-cycle strobe, so every edge with done high
    // carries exactly one result. Values are the ones held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            seen.status = status;
            seen.rvalue = result_value;
            seen.fpos   = found_position;
            seen.length = current_length;
            seen.empty  = is_empty;
            tracker.check_response(seen);
        end
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Present one item and hold it until the edge where busy is low; the
    // scoreboard is updated at that edge. At the end of a burst start drops
    // for a random gap, if any; in a burst it stays high into the next item.
    task automatic send_item(input logic [3:0] op, input logic [6:0] pos,
                             input logic [31:0] val);
        int gap;
        start     <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= val;
        do @(posedge clk); while (busy !== 1'b0);
        tracker.note_request(op, pos, val);
        ops_seen[op]++;
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(20, 80))
                                                     : int'($urandom_range(1, 12));
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending until every outstanding result has been checked.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (tracker.pending_outcomes.size() != 0);
        drains++;
    endtask

    // Mostly values from a small pool so searches hit and duplicates occur;
    // sometimes a value already in the list, sometimes anything at all.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return value_pool[$urandom_range(0, 7)];
        if (r == 6 && tracker.len > 0)
            return tracker.cells[$urandom_range(0, tracker.len - 1)];
        return $urandom;
    endfunction

    // Any 7-bit position, for operations that ignore it.
    function automatic logic [6:0] any_position();
        return 7'($urandom_range(0, 127));
    endfunction

    // Mostly a legal 1-based position up to upper, otherwise the first one
    // past the end, zero, or any 7-bit value.
    function automatic logic [6:0] pick_position(int upper);
        int r;
        r = $urandom_range(0, 19);
        if (upper >= 1 && r < 16)
            return 7'($urandom_range(1, upper));
        if (r < 18)
            return 7'(upper + 1);
        if (r == 18)
            return '0;
        return any_position();
    endfunction

    task automatic random_item(input phase_t ph);
        int         r;
        int         ins_w;
        int         del_w;
        logic [3:0] op;
        if (ph == PH_NOISE)
        begin
            send_item(4'($urandom_range(0, OP_CODE_MAX)), any_position(), $urandom);
            return;
        end
        r = $urandom_range(0, 99);
        if (!tracker.list_live)
        begin
            // no list: mostly bring one up, occasionally poke at the void
            op = (r < 85) ? OP_CREATE : 4'($urandom_range(OP_DESTROY, OP_CODE_MAX));
            send_item(op, any_position(), pick_value());
            return;
        end
        ins_w = (ph == PH_GROW) ? 60 : (ph == PH_SHRINK) ? 10 : 30;
        del_w = (ph == PH_GROW) ? 10 : (ph == PH_SHRINK) ? 55 : 25;
        if (r < ins_w)
            send_item(OP_INSERT, pick_position(tracker.len + 1), pick_value());
        else if (r < ins_w + del_w)
            send_item(OP_DELETE, pick_position(tracker.len), pick_value());
        else
        begin
            r = $urandom_range(0, 19);
            if (r < 5)
                send_item(OP_GET, pick_position(tracker.len), pick_value());
            else if (r < 9)
                send_item(OP_LOCATE, any_position(), pick_value());
            else if (r < 13)
                send_item(OP_PRED, any_position(), pick_value());
            else if (r < 17)
                send_item(OP_SUCC, any_position(), pick_value());
            else if (ph != PH_LIFECYCLE)
                send_item(OP_GET, pick_position(tracker.len), pick_value());
            else if (r == 17)
                send_item(OP_CLEAR, any_position(), pick_value());
            else if (r == 18)
                send_item(OP_DESTROY, any_position(), pick_value());
            else
            begin
                // repeated create or an unused code: neither may touch the list
                op = $urandom_range(0, 1) ? OP_CREATE
                                          : 4'($urandom_range(OP_UNUSED_LOW, OP_CODE_MAX));
                send_item(op, any_position(), pick_value());
            end
        end
    endtask

    // Grow the list to capacity, hammer it while full, probe the top end,
    // then let everything settle.
    task automatic fill_to_capacity();
        int k;
        if (!tracker.list_live)
            send_item(OP_CREATE, any_position(), pick_value());
        while (tracker.len < CAPACITY)
            send_item(OP_INSERT, 7'($urandom_range(1, tracker.len + 1)), pick_value());
        for (k = 0; k < 6; k++)
            send_item(OP_INSERT, pick_position(tracker.len + 1), pick_value());
        send_item(OP_GET, 7'(CAPACITY), pick_value());
        send_item(OP_GET, 7'(CAPACITY + 1), pick_value());
        send_item(OP_LOCATE, '0, tracker.cells[CAPACITY-1]);
        send_item(OP_SUCC, '0, tracker.cells[CAPACITY-2]);
        send_item(OP_PRED, '0, tracker.cells[CAPACITY-1]);
        send_item(OP_DELETE, 7'(CAPACITY), pick_value());
        drain();
    endtask

    initial
    begin
        phase_t ph;
        int     round_len;
        int     k;
        int     guard;
        int     codes_hit;
        outcome_t left;

        tracker    = new();
        burst_left = 1;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (k = 5; k < 8; k++)
            value_pool[k] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: operations on a missing list, double create,
        // bounds of insert/get/delete, searches at both ends, signed extremes.
        send_item(OP_GET,     7'd1,   32'h0);
        send_item(OP_INSERT,  7'd1,   32'h5);
        send_item(OP_CODE_MAX, 7'd0,  32'h0);
        send_item(OP_CREATE,  7'd0,   32'h0);
        send_item(OP_CREATE,  7'd0,   32'h0);
        send_item(OP_GET,     7'd1,   32'h0);
        send_item(OP_LOCATE,  7'd0,   32'h0);
        send_item(OP_INSERT,  7'd0,   32'h1);
        send_item(OP_INSERT,  7'd2,   32'h1);
        send_item(OP_INSERT,  7'd1,   32'h8000_0000);
        send_item(OP_INSERT,  7'd2,   32'h7FFF_FFFF);
        send_item(OP_INSERT,  7'd1,   32'hFFFF_FFFF);
        send_item(OP_INSERT,  7'd127, 32'h2);
        send_item(OP_GET,     7'd3,   32'h0);
        send_item(OP_LOCATE,  7'd0,   32'h7FFF_FFFF);
        send_item(OP_PRED,    7'd0,   32'hFFFF_FFFF);
        send_item(OP_PRED,    7'd0,   32'h7FFF_FFFF);
        send_item(OP_SUCC,    7'd0,   32'h7FFF_FFFF);
        send_item(OP_SUCC,    7'd0,   32'hFFFF_FFFF);
        send_item(OP_DELETE,  7'd2,   32'h0);
        send_item(OP_DELETE,  7'd3,   32'h0);
        send_item(OP_UNUSED_LOW, 7'd0, 32'h0);
        send_item(OP_CLEAR,   7'd0,   32'h0);
        send_item(OP_DESTROY, 7'd0,   32'h0);
        send_item(OP_DESTROY, 7'd0,   32'h0);
        drain();

        // Random rounds. The first one always fills the list and keeps inserting
        // while it is full; later rounds pick a flavor at random.
        k = items_sent;
        ph = PH_FILL;
        while (items_sent < k + RANDOM_ITEMS)
        begin
            if (ph == PH_FILL)
                fill_to_capacity();
            else
            begin
                round_len = $urandom_range(10, 60);
                repeat (round_len)
                    random_item(ph);
                if ($urandom_range(0, 3) == 0)
                    drain();
            end
            case ($urandom_range(0, 9))
                0, 1, 2: ph = PH_MIX;
                3, 4:    ph = PH_GROW;
                5, 6:    ph = PH_SHRINK;
                7:       ph = PH_NOISE;
                8:       ph = PH_LIFECYCLE;
                default: ph = PH_FILL;
            endcase
        end

        // Wind down: stop sending, collect what is still in flight, then keep
        // watching for any stray result.
        start <= 1'b0;
        guard = 0;
        while (tracker.pending_outcomes.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        while (tracker.pending_outcomes.size() != 0)
        begin
            left = tracker.pending_outcomes.pop_front();
            tracker.failures++;
            $display("%0t ns MISMATCH missing result: expected 0x%0h, actual none",
                     $time, left);
        end

        codes_hit = 0;
        for (k = 0; k < 16; k++)
            if (ops_seen[k] != 0)
                codes_hit++;
        $display("Covered %0d items across %0d operation codes, %0d results checked.",
                 items_sent, codes_hit, tracker.checked);
        $display("Longest list %0d entries, %0d inserts refused as full, %0d drains.",
                 tracker.peak_len, tracker.full_refusals, drains);
        if (tracker.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
